>>> hdl/bst_pkg.sv
// Shared types and constants of the bencode stream tokenizer.
package bst_pkg;

    localparam logic [7:0] C_INT   = 8'h69;
    localparam logic [7:0] C_LIST  = 8'h6C;
    localparam logic [7:0] C_DICT  = 8'h64;
    localparam logic [7:0] C_END   = 8'h65;
    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;

    localparam logic [2:0] EV_INT     = 3'd0;
    localparam logic [2:0] EV_STR_HDR = 3'd1;
    localparam logic [2:0] EV_STR_BYTE = 3'd2;
    localparam logic [2:0] EV_LIST    = 3'd3;
    localparam logic [2:0] EV_DICT    = 3'd4;
    localparam logic [2:0] EV_CLOSE   = 3'd5;
    localparam logic [2:0] EV_DONE    = 3'd6;
    localparam logic [2:0] EV_ERROR   = 3'd7;

    localparam logic [2:0] ERR_PREMATURE = 3'd0;
    localparam logic [2:0] ERR_ITEM      = 3'd1;
    localparam logic [2:0] ERR_DIGIT     = 3'd2;
    localparam logic [2:0] ERR_TERM      = 3'd3;
    localparam logic [2:0] ERR_DEEP      = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [1:0] {
        K_LIST  = 2'd0,
        K_KEY   = 2'd1,
        K_VALUE = 2'd2
    } t_kind;

    typedef enum logic [9:0] {
        M_ITEM    = 10'b0000000001,
        M_INT_ST  = 10'b0000000010,
        M_INT0    = 10'b0000000100,
        M_INT1    = 10'b0000001000,
        M_INT2    = 10'b0000010000,
        M_STR0    = 10'b0000100000,
        M_STR1    = 10'b0001000000,
        M_STR2    = 10'b0010000000,
        M_BODY    = 10'b0100000000,
        M_ENDLESS = 10'b1000000000
    } t_mode;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [5:0]         depth;
        logic               key;
        logic [2:0]         code;
        logic               eor;
    } t_event;

    typedef struct packed {
        logic   two;
        t_event ev0;
        t_event ev1;
    } t_pair;

    function automatic t_kind toggle(input t_kind k);
        t_kind r;
        r = k;
        if (k == K_KEY) begin
            r = K_VALUE;
        end else if (k == K_VALUE) begin
            r = K_KEY;
        end
        return r;
    endfunction

endpackage

>>> hdl/bst_byte_if.sv
// Input byte channel.
interface bst_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;
    modport source(output valid, output data_byte, output final_byte, input ready);
    modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

>>> hdl/bst_event_if.sv
// Output event channel.
interface bst_event_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic signed [31:0] event_value;
    logic [5:0]         nest_depth;
    logic               is_dict_key;
    logic [2:0]         error_code;
    logic               end_of_run;
    modport source(output valid, output event_kind, output event_value, output nest_depth,
                   output is_dict_key, output error_code, output end_of_run, input ready);
    modport sink(input valid, input event_kind, input event_value, input nest_depth,
                 input is_dict_key, input error_code, input end_of_run, output ready);
endinterface

>>> hdl/bst_front.sv
// Parser front end: accepts bytes, updates parse state and stack, emits event pairs.
module bst_front #(
    parameter int MAX_DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bst_byte_if.sink       i_byte,
    input  logic           i_q_ready,
    output logic           o_q_valid,
    output bst_pkg::t_pair o_q_pair
);
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    bst_pkg::t_mode r_mode, n_mode;
    logic [31:0]    r_acc, n_acc;
    logic           r_neg, n_neg;
    logic [30:0]    r_pay, n_pay;
    logic [DW-1:0]  r_depth, n_depth;
    bst_pkg::t_kind r_top, n_top;
    bst_pkg::t_kind r_below;
    logic           r_halt, n_halt;

    bst_pkg::t_kind mem [MAX_DEPTH];
    logic           mem_we;
    logic [DW-1:0]  waddr_full, raddr_full;
    logic [AW-1:0]  waddr, raddr;

    logic           fire, h_vld, f_vld, is_dig, is_str, in_key;
    logic [7:0]     b, term;
    logic [3:0]     dig;
    logic [31:0]    v;
    bst_pkg::t_event h_ev, f_ev;

    assign fire  = i_byte.valid && i_byte.ready;
    assign i_byte.ready = i_q_ready;
    assign b     = i_byte.data_byte;
    assign dig   = b[3:0];
    assign is_dig = (b >= bst_pkg::C_ZERO) && (b <= bst_pkg::C_NINE);
    assign is_str = (r_mode == bst_pkg::M_STR0) || (r_mode == bst_pkg::M_STR1) ||
                    (r_mode == bst_pkg::M_STR2);
    assign term   = is_str ? bst_pkg::C_COLON : bst_pkg::C_END;
    assign in_key = (r_depth != '0) && (r_top == bst_pkg::K_KEY);
    assign v      = r_neg ? (32'd0 - r_acc) : r_acc;

    assign waddr_full = r_depth - DW'(1);
    assign waddr      = waddr_full[AW-1:0];
    assign raddr_full = n_depth - DW'(2);
    assign raddr      = raddr_full[AW-1:0];

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_pay   = r_pay;
        n_depth = r_depth;
        n_top   = r_top;
        n_halt  = r_halt;
        h_vld   = 1'b0;
        h_ev    = '0;
        h_ev.depth = 6'(r_depth);
        f_vld   = 1'b0;
        f_ev    = '0;
        mem_we  = 1'b0;
        if (fire && !r_halt) begin
            case (r_mode)
                bst_pkg::M_INT0, bst_pkg::M_STR0: begin
                    if (b == bst_pkg::C_ZERO) begin
                        n_acc  = '0;
                        n_mode = is_str ? bst_pkg::M_STR2 : bst_pkg::M_INT2;
                    end else if (is_dig) begin
                        n_acc  = {28'd0, dig};
                        n_mode = is_str ? bst_pkg::M_STR1 : bst_pkg::M_INT1;
                    end else begin
                        h_vld = 1'b1;
                        h_ev.kind = bst_pkg::EV_ERROR;
                        h_ev.code = bst_pkg::ERR_DIGIT;
                        n_halt = 1'b1;
                    end
                end
                bst_pkg::M_INT1, bst_pkg::M_STR1, bst_pkg::M_INT2, bst_pkg::M_STR2: begin
                    if (is_dig && (r_mode == bst_pkg::M_INT1 || r_mode == bst_pkg::M_STR1)) begin
                        n_acc = {r_acc[28:0], 3'b0} + {r_acc[30:0], 1'b0} + {28'd0, dig};
                    end else if (b == term) begin
                        n_acc = '0;
                        n_neg = 1'b0;
                        h_vld = 1'b1;
                        h_ev.value = v;
                        if (!is_str) begin
                            h_ev.kind = bst_pkg::EV_INT;
                            n_mode = bst_pkg::M_ITEM;
                            if (r_depth != '0) n_top = bst_pkg::toggle(r_top);
                        end else begin
                            h_ev.kind = bst_pkg::EV_STR_HDR;
                            h_ev.key  = in_key;
                            if (v == '0) begin
                                n_mode = bst_pkg::M_ITEM;
                                if (r_depth != '0) n_top = bst_pkg::toggle(r_top);
                            end else if (v[31]) begin
                                n_mode = bst_pkg::M_ENDLESS;
                            end else begin
                                n_pay  = v[30:0];
                                n_mode = bst_pkg::M_BODY;
                            end
                        end
                    end else begin
                        h_vld = 1'b1;
                        h_ev.kind = bst_pkg::EV_ERROR;
                        h_ev.code = bst_pkg::ERR_TERM;
                        n_halt = 1'b1;
                    end
                end
                bst_pkg::M_INT_ST: begin
                    if (b == bst_pkg::C_MINUS) begin
                        n_neg  = 1'b1;
                        n_mode = bst_pkg::M_INT0;
                    end else if (b == bst_pkg::C_ZERO) begin
                        n_acc  = '0;
                        n_mode = bst_pkg::M_INT2;
                    end else if (is_dig) begin
                        n_acc  = {28'd0, dig};
                        n_mode = bst_pkg::M_INT1;
                    end else begin
                        h_vld = 1'b1;
                        h_ev.kind = bst_pkg::EV_ERROR;
                        h_ev.code = bst_pkg::ERR_DIGIT;
                        n_halt = 1'b1;
                    end
                end
                bst_pkg::M_BODY: begin
                    h_vld = 1'b1;
                    h_ev.kind  = bst_pkg::EV_STR_BYTE;
                    h_ev.value = {24'd0, b};
                    h_ev.key   = in_key;
                    n_pay = r_pay - 31'd1;
                    if (n_pay == '0) begin
                        n_mode = bst_pkg::M_ITEM;
                        if (r_depth != '0) n_top = bst_pkg::toggle(r_top);
                    end
                end
                bst_pkg::M_ENDLESS: begin
                    h_vld = 1'b1;
                    h_ev.kind  = bst_pkg::EV_STR_BYTE;
                    h_ev.value = {24'd0, b};
                    h_ev.key   = in_key;
                end
                bst_pkg::M_ITEM: begin
                    if ((r_depth != '0) && (r_top != bst_pkg::K_VALUE) && (b == bst_pkg::C_END)) begin
                        n_depth = r_depth - DW'(1);
                        h_vld = 1'b1;
                        h_ev.kind  = bst_pkg::EV_CLOSE;
                        h_ev.depth = 6'(n_depth);
                        n_top = bst_pkg::toggle(r_below);
                    end else if (in_key) begin
                        n_acc = '0;
                        n_neg = 1'b0;
                        if (b == bst_pkg::C_MINUS) begin
                            n_neg  = 1'b1;
                            n_mode = bst_pkg::M_STR0;
                        end else if (b == bst_pkg::C_ZERO) begin
                            n_mode = bst_pkg::M_STR2;
                        end else if (is_dig) begin
                            n_acc  = {28'd0, dig};
                            n_mode = bst_pkg::M_STR1;
                        end else begin
                            h_vld = 1'b1;
                            h_ev.kind = bst_pkg::EV_ERROR;
                            h_ev.code = bst_pkg::ERR_DIGIT;
                            n_halt = 1'b1;
                        end
                    end else if (b == bst_pkg::C_INT) begin
                        n_acc  = '0;
                        n_neg  = 1'b0;
                        n_mode = bst_pkg::M_INT_ST;
                    end else if (b == bst_pkg::C_LIST || b == bst_pkg::C_DICT) begin
                        h_vld = 1'b1;
                        if (r_depth == DW'(MAX_DEPTH)) begin
                            h_ev.kind = bst_pkg::EV_ERROR;
                            h_ev.code = bst_pkg::ERR_DEEP;
                            n_halt = 1'b1;
                        end else begin
                            h_ev.kind = (b == bst_pkg::C_LIST) ? bst_pkg::EV_LIST
                                                               : bst_pkg::EV_DICT;
                            mem_we  = (r_depth != '0);
                            n_top   = (b == bst_pkg::C_LIST) ? bst_pkg::K_LIST : bst_pkg::K_KEY;
                            n_depth = r_depth + DW'(1);
                        end
                    end else if (is_dig) begin
                        n_neg = 1'b0;
                        if (b == bst_pkg::C_ZERO) begin
                            n_acc  = '0;
                            n_mode = bst_pkg::M_STR2;
                        end else begin
                            n_acc  = {28'd0, dig};
                            n_mode = bst_pkg::M_STR1;
                        end
                    end else begin
                        h_vld = 1'b1;
                        h_ev.kind = bst_pkg::EV_ERROR;
                        h_ev.code = bst_pkg::ERR_ITEM;
                        n_halt = 1'b1;
                    end
                end
                default: begin
                    n_mode = bst_pkg::M_ITEM;
                end
            endcase
        end
        if (fire && i_byte.final_byte) begin
            if (!n_halt) begin
                f_vld = 1'b1;
                if (n_mode == bst_pkg::M_ITEM && n_depth == '0) begin
                    f_ev.kind = bst_pkg::EV_DONE;
                end else begin
                    f_ev.kind  = bst_pkg::EV_ERROR;
                    f_ev.code  = bst_pkg::ERR_PREMATURE;
                    f_ev.depth = 6'(n_depth);
                end
            end
            n_mode  = bst_pkg::M_ITEM;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_pay   = '0;
            n_depth = '0;
            n_halt  = 1'b0;
        end
    end

    always_comb begin
        o_q_valid = fire && (h_vld || f_vld);
        o_q_pair  = '0;
        if (h_vld) begin
            o_q_pair.two = f_vld;
            o_q_pair.ev0 = h_ev;
            o_q_pair.ev0.eor = !f_vld;
            o_q_pair.ev1 = f_ev;
            o_q_pair.ev1.eor = 1'b1;
        end else begin
            o_q_pair.ev0 = f_ev;
            o_q_pair.ev0.eor = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= bst_pkg::M_ITEM;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_pay   <= '0;
            r_depth <= '0;
            r_top   <= bst_pkg::K_LIST;
            r_halt  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_pay   <= n_pay;
            r_depth <= n_depth;
            r_top   <= n_top;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= r_top;
        end
        if (mem_we && waddr == raddr) begin
            r_below <= r_top;
        end else begin
            r_below <= mem[raddr];
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_DEPTH))
        else $error("stack depth beyond limit");
    a_final_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_byte.final_byte |=> r_depth == '0 && !r_halt && r_mode == bst_pkg::M_ITEM)
        else $error("parser not re-armed after last byte");
    a_halt_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_halt) |-> $past(o_q_valid) && $past(o_q_pair.ev0.kind) == bst_pkg::EV_ERROR)
        else $error("halt without error event");
endmodule

>>> hdl/bst_queue.sv
// Short queue of event pairs between parser and output stage.
module bst_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bst_pkg::t_pair i_pair,
    output logic           o_space,
    output logic           o_valid,
    output bst_pkg::t_pair o_pair,
    input  logic           i_pop
);
    bst_pkg::t_pair             mem [bst_pkg::QDEPTH];
    logic [bst_pkg::QAW-1:0]    r_wp, r_rp;
    logic [bst_pkg::QAW:0]      r_cnt;
    logic                       do_push, do_pop;

    assign o_space = r_cnt != (bst_pkg::QAW + 1)'(bst_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_pair  = mem[r_rp];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (bst_pkg::QAW + 1)'(do_push) - (bst_pkg::QAW + 1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) mem[r_wp] <= i_pair;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (bst_pkg::QAW + 1)'(bst_pkg::QDEPTH))
        else $error("queue count out of range");
endmodule

>>> hdl/bst_back.sv
// Output stage: splits event pairs into single words behind an output register.
module bst_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  bst_pkg::t_pair i_q_pair,
    output logic           o_q_pop,
    bst_event_if.source    o_event
);
    logic            r_valid, r_half;
    bst_pkg::t_event r_ev;
    logic            load;

    assign load    = i_q_valid && (!r_valid || o_event.ready);
    assign o_q_pop = load && (!i_q_pair.two || r_half);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= i_q_pair.two && !r_half;
            end else if (o_event.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_ev <= r_half ? i_q_pair.ev1 : i_q_pair.ev0;
    end

    assign o_event.valid       = r_valid;
    assign o_event.event_kind  = r_ev.kind;
    assign o_event.event_value = r_ev.value;
    assign o_event.nest_depth  = r_ev.depth;
    assign o_event.is_dict_key = r_ev.key;
    assign o_event.error_code  = r_ev.code;
    assign o_event.end_of_run  = r_ev.eor;
endmodule

>>> hdl/bencode_stream_tokenizer.sv
// Top level of the bencode stream tokenizer.
// Input channel i_byte carries one buffer byte per word with a flag on the
// buffer's last byte; output channel o_event carries one event per word
// (integer, string header, string byte, open, close, done or error) with
// its nesting depth, dict-key flag, error code and an end-of-run mark on
// the last event a byte causes. Both are valid/ready channels.
// A byte is taken every cycle while the pair queue has room; each byte is
// parsed in its accept cycle; its events pass the queue and the output
// register to o_event. Bursts of two-event bytes drain at one event a cycle,
// while the receiver is ready, from the four-entry queue. The parse state
// and a container stack of MAX_DEPTH entries (top held in a register, the
// rest in a memory read one level ahead) are updated once per byte.
// After an error no events come until the last byte of the buffer, which
// re-arms the parser. Reset clears parse state, queue and output register.
// When the receiver stalls the output register holds, the queue fills and
// i_byte.ready drops until room frees up.
module bencode_stream_tokenizer #(
    parameter int MAX_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bst_byte_if.sink    i_byte,
    bst_event_if.source o_event
);
    logic           q_space, push, q_valid, pop;
    bst_pkg::t_pair push_pair, head_pair;

    bst_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_q_ready (q_space),
        .o_q_valid (push),
        .o_q_pair  (push_pair)
    );

    bst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (push_pair),
        .o_space (q_space),
        .o_valid (q_valid),
        .o_pair  (head_pair),
        .i_pop   (pop)
    );

    bst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_pair  (head_pair),
        .o_q_pop   (pop),
        .o_event   (o_event)
    );
endmodule

>>> bench/bst_event_checker.sv
// Event checker of the bencode stream tokenizer: predicts events per byte and compares.
`timescale 1ns / 100ps
module bst_event_checker #(
    parameter int MAX_DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bst_byte_if  i_byte_mon,
    bst_event_if i_event_mon,
    output int   o_fail_cnt,
    output int   o_pending,
    output int   o_checked
);

    typedef enum int {
        PM_ITEM, PM_INT_SIGN, PM_INT_FIRST, PM_INT_MORE, PM_INT_ZERO,
        PM_LEN_FIRST, PM_LEN_MORE, PM_LEN_ZERO, PM_PAYLOAD, PM_PAYLOAD_ENDLESS
    } t_parse_mode;

    t_parse_mode     mode;
    logic [31:0]     accum;
    logic            negative;
    logic [30:0]     left;
    bst_pkg::t_kind  stack_kind [MAX_DEPTH];
    int              depth;
    logic            halted;
    bst_pkg::t_event event_q [$];
    int              fail_cnt;
    int              checked;
    int              pending;

    assign o_fail_cnt = fail_cnt;
    assign o_pending  = pending;
    assign o_checked  = checked;

    function automatic void clear_parser();
        mode     = PM_ITEM;
        accum    = '0;
        negative = 1'b0;
        left     = '0;
        depth    = 0;
        halted   = 1'b0;
        foreach (stack_kind[k]) stack_kind[k] = bst_pkg::K_LIST;
    endfunction

    function automatic void emit(input logic [2:0] kind, input logic [31:0] value,
                                 input logic key, input logic [2:0] code);
        bst_pkg::t_event e;
        e.kind  = kind;
        e.value = value;
        e.depth = depth[5:0];
        e.key   = key;
        e.code  = code;
        e.eor   = 1'b0;
        event_q.push_back(e);
    endfunction

    function automatic void raise(input logic [2:0] code);
        emit(bst_pkg::EV_ERROR, '0, 1'b0, code);
        halted = 1'b1;
    endfunction

    function automatic logic key_side();
        return depth > 0 && stack_kind[depth - 1] == bst_pkg::K_KEY;
    endfunction

    function automatic logic digit(input logic [7:0] b);
        return b >= bst_pkg::C_ZERO && b <= bst_pkg::C_NINE;
    endfunction

    function automatic void item_closed();
        mode = PM_ITEM;
        if (depth > 0) stack_kind[depth - 1] = bst_pkg::toggle(stack_kind[depth - 1]);
    endfunction

    function automatic void lead_digit(input logic [7:0] b, input logic is_len);
        if (b == bst_pkg::C_ZERO) begin
            accum = '0;
            mode  = is_len ? PM_LEN_ZERO : PM_INT_ZERO;
        end else if (digit(b)) begin
            accum = 32'(b - bst_pkg::C_ZERO);
            mode  = is_len ? PM_LEN_MORE : PM_INT_MORE;
        end else begin
            raise(bst_pkg::ERR_DIGIT);
        end
    endfunction

    function automatic void number_done(input logic is_len);
        logic [31:0] v;
        v        = negative ? (32'd0 - accum) : accum;
        accum    = '0;
        negative = 1'b0;
        if (!is_len) begin
            emit(bst_pkg::EV_INT, v, 1'b0, 3'd0);
            item_closed();
        end else begin
            emit(bst_pkg::EV_STR_HDR, v, key_side(), 3'd0);
            if (v == 0) begin
                item_closed();
            end else if (v[31]) begin
                mode = PM_PAYLOAD_ENDLESS;
            end else begin
                left = v[30:0];
                mode = PM_PAYLOAD;
            end
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        bst_pkg::t_kind top;
        logic           is_len;
        case (mode)
            PM_INT_FIRST, PM_LEN_FIRST: begin
                lead_digit(b, mode == PM_LEN_FIRST);
            end
            PM_INT_MORE, PM_LEN_MORE, PM_INT_ZERO, PM_LEN_ZERO: begin
                is_len = (mode == PM_LEN_MORE || mode == PM_LEN_ZERO);
                if ((mode == PM_INT_MORE || mode == PM_LEN_MORE) && digit(b)) begin
                    accum = accum * 32'd10 + 32'(b - bst_pkg::C_ZERO);
                end else if (b == (is_len ? bst_pkg::C_COLON : bst_pkg::C_END)) begin
                    number_done(is_len);
                end else begin
                    raise(bst_pkg::ERR_TERM);
                end
            end
            PM_INT_SIGN: begin
                if (b == bst_pkg::C_MINUS) begin
                    negative = 1'b1;
                    mode     = PM_INT_FIRST;
                end else begin
                    lead_digit(b, 1'b0);
                end
            end
            PM_PAYLOAD: begin
                emit(bst_pkg::EV_STR_BYTE, 32'(b), key_side(), 3'd0);
                left = left - 31'd1;
                if (left == 0) item_closed();
            end
            PM_PAYLOAD_ENDLESS: begin
                emit(bst_pkg::EV_STR_BYTE, 32'(b), key_side(), 3'd0);
            end
            default: begin
                top = depth > 0 ? stack_kind[depth - 1] : bst_pkg::K_VALUE;
                if (depth > 0 && top != bst_pkg::K_VALUE && b == bst_pkg::C_END) begin
                    depth--;
                    emit(bst_pkg::EV_CLOSE, '0, 1'b0, 3'd0);
                    item_closed();
                end else if (depth > 0 && top == bst_pkg::K_KEY) begin
                    accum    = '0;
                    negative = 1'b0;
                    if (b == bst_pkg::C_MINUS) begin
                        negative = 1'b1;
                        mode     = PM_LEN_FIRST;
                    end else begin
                        lead_digit(b, 1'b1);
                    end
                end else if (b == bst_pkg::C_INT) begin
                    accum    = '0;
                    negative = 1'b0;
                    mode     = PM_INT_SIGN;
                end else if (b == bst_pkg::C_LIST || b == bst_pkg::C_DICT) begin
                    if (depth >= MAX_DEPTH) begin
                        raise(bst_pkg::ERR_DEEP);
                    end else begin
                        emit(b == bst_pkg::C_LIST ? bst_pkg::EV_LIST : bst_pkg::EV_DICT,
                             '0, 1'b0, 3'd0);
                        stack_kind[depth] = (b == bst_pkg::C_LIST) ? bst_pkg::K_LIST
                                                                   : bst_pkg::K_KEY;
                        depth++;
                    end
                end else if (digit(b)) begin
                    negative = 1'b0;
                    lead_digit(b, 1'b1);
                end else begin
                    raise(bst_pkg::ERR_ITEM);
                end
            end
        endcase
    endfunction

    function automatic void predict_word(input logic [7:0] b, input logic fin);
        int prior_cnt;
        prior_cnt = event_q.size();
        if (!halted) parse_byte(b);
        if (fin) begin
            if (!halted) begin
                if (mode == PM_ITEM && depth == 0) begin
                    emit(bst_pkg::EV_DONE, '0, 1'b0, 3'd0);
                    event_q[event_q.size() - 1].depth = '0;
                end else begin
                    emit(bst_pkg::EV_ERROR, '0, 1'b0, bst_pkg::ERR_PREMATURE);
                end
            end
            clear_parser();
        end
        if (event_q.size() > prior_cnt) event_q[event_q.size() - 1].eor = 1'b1;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: event %0d %s mismatch: got %0h, want %0h", $realtime, checked, what,
                 got, want);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        bst_pkg::t_event want;
        if (!i_rst_n) begin
            clear_parser();
            event_q.delete();
            fail_cnt = 0;
            checked  = 0;
        end else begin
            if (i_byte_mon.valid && i_byte_mon.ready) begin
                predict_word(i_byte_mon.data_byte, i_byte_mon.final_byte);
            end
            if (i_event_mon.valid && i_event_mon.ready) begin
                if (event_q.size() == 0) begin
                    $display("%0t: unexpected event kind %0d", $realtime,
                             i_event_mon.event_kind);
                    fail_cnt++;
                end else begin
                    want = event_q.pop_front();
                    if (i_event_mon.event_kind != want.kind)
                        report("kind", 32'(i_event_mon.event_kind), 32'(want.kind));
                    if (i_event_mon.event_value != want.value)
                        report("value", i_event_mon.event_value, want.value);
                    if (i_event_mon.nest_depth != want.depth)
                        report("depth", 32'(i_event_mon.nest_depth), 32'(want.depth));
                    if (i_event_mon.is_dict_key != want.key)
                        report("key", 32'(i_event_mon.is_dict_key), 32'(want.key));
                    if (i_event_mon.error_code != want.code)
                        report("code", 32'(i_event_mon.error_code), 32'(want.code));
                    if (i_event_mon.end_of_run != want.eor)
                        report("end_of_run", 32'(i_event_mon.end_of_run), 32'(want.eor));
                end
                checked++;
            end
        end
        pending = event_q.size();
    end

endmodule

>>> bench/bencode_stream_tokenizer_tb.sv
// Testbench top of the bencode stream tokenizer: stimulus, handshakes and verdict.
`timescale 1ns / 100ps
module bencode_stream_tokenizer_tb;

    localparam int DEPTH_LIMIT = 32;
    localparam int CYCLE_LIMIT = 600000;

    logic i_clk;
    logic i_rst_n;
    bst_byte_if  byte_ch ();
    bst_event_if event_ch ();

    int   fail_cnt;
    int   pending;
    int   checked;
    int   cycles;
    int   words_sent;
    int   buffers_sent;
    logic tx_idle;
    logic rx_idle;
    logic rx_hold;
    logic [7:0] buf_q [$];

    bencode_stream_tokenizer #(.MAX_DEPTH(DEPTH_LIMIT)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_event (event_ch)
    );

    bst_event_checker #(.MAX_DEPTH(DEPTH_LIMIT)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_mon  (byte_ch),
        .i_event_mon (event_ch),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        rx_hold = 1'b0;
        wait (words_sent >= 300);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        int g;
        event_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            g = rx_idle ? $urandom_range(0, 14) : 0;
            if (g > 0 || rx_hold) begin
                event_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            event_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!event_ch.valid) @(posedge i_clk);
        end
    end

    task automatic put_word(input logic [7:0] b, input logic fin);
        int g;
        g = tx_idle ? $urandom_range(0, 14) : 0;
        if (g > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= b;
        byte_ch.final_byte <= fin;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_buf();
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        foreach (buf_q[k]) put_word(buf_q[k], k == buf_q.size() - 1);
        buffers_sent++;
    endtask

    task automatic send_text(input string s);
        buf_q.delete();
        for (int k = 0; k < s.len(); k++) buf_q.push_back(s[k]);
        send_buf();
    endtask

    function automatic void push_dec(input logic [63:0] v);
        logic [7:0] digits [$];
        do begin
            digits.push_front(8'(v % 10) + bst_pkg::C_ZERO);
            v = v / 10;
        end while (v != 0);
        foreach (digits[k]) buf_q.push_back(digits[k]);
    endfunction

    function automatic void gen_string();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        push_dec(64'(n));
        buf_q.push_back(bst_pkg::C_COLON);
        repeat (n) buf_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void gen_value(input int lvl);
        int pick;
        int n;
        pick = (lvl >= 4) ? $urandom_range(0, 5) : $urandom_range(0, 9);
        if (pick <= 2) begin
            buf_q.push_back(bst_pkg::C_INT);
            if ($urandom_range(0, 2) == 0) buf_q.push_back(bst_pkg::C_MINUS);
            if ($urandom_range(0, 5) == 0) begin
                buf_q.push_back(bst_pkg::C_ZERO);
            end else if ($urandom_range(0, 4) == 0) begin
                push_dec({$urandom, $urandom} % 64'd100000000000);
            end else begin
                push_dec(64'($urandom_range(1, 99999)));
            end
            buf_q.push_back(bst_pkg::C_END);
        end else if (pick <= 5) begin
            gen_string();
        end else begin
            buf_q.push_back(pick <= 7 ? bst_pkg::C_LIST : bst_pkg::C_DICT);
            n = $urandom_range(0, 3);
            repeat (n) begin
                if (pick > 7) gen_string();
                gen_value(lvl + 1);
            end
            buf_q.push_back(bst_pkg::C_END);
        end
    endfunction

    initial begin
        int kind;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = '0;
        byte_ch.final_byte = 1'b0;
        tx_idle            = 1'b1;
        rx_idle            = 1'b1;
        cycles             = 0;
        words_sent         = 0;
        buffers_sent       = 0;
        i_rst_n            = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("i42e");
        send_text("i-0e");
        send_text("i03e");
        send_text("i4294967297ei-2147483648e");
        send_text("4:spam0:");
        send_text("lei7e");
        send_text("d3:keyli1e2:abee");
        send_text("d-0:i1ee");
        send_text("d1:ae");
        send_text("dxe");
        send_text("d-1:abc");
        send_text("3000000000:xyz");
        send_text("i12");
        send_text("x");
        send_text("ix");
        send_text("i5exi6e");
        send_text("e");
        send_text({33{"l"}});
        send_text({{32{"l"}}, {32{"e"}}});
        buf_q = '{8'h32, bst_pkg::C_COLON, 8'hFF, 8'h00};
        send_buf();

        while (words_sent < 800) begin
            buf_q.delete();
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 6)) buf_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                gen_value(0);
                if ($urandom_range(0, 4) == 0) gen_value(0);
                if (kind == 1) begin
                    buf_q[$urandom_range(0, buf_q.size() - 1)] = 8'($urandom_range(0, 255));
                end else if (kind == 2 && buf_q.size() > 1) begin
                    buf_q = buf_q[0:$urandom_range(0, buf_q.size() - 2)];
                end
            end
            send_buf();
        end
        byte_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("sent %0d bytes in %0d buffers, checked %0d events", words_sent,
                 buffers_sent, checked);
        $display("covered nesting to the depth limit, errors, wraps and a long output stall");
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
